// ===== src/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary settings menu package
// Shared event codes, menu entry codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int unsigned THR_WIDTH  = 16;
    localparam int unsigned VAL_WIDTH  = 4;
    localparam int unsigned IDX_WIDTH  = 2;

    typedef enum logic [1:0] {
        EV_CW    = 2'd0,
        EV_CCW   = 2'd1,
        EV_PRESS = 2'd2
    } ev_kind_t;

    typedef enum logic [1:0] {
        ENTRY_EXIT      = 2'd0,
        ENTRY_TRANSMIT  = 2'd1,
        ENTRY_INTENSITY = 2'd2,
        ENTRY_ID        = 2'd3
    } entry_t;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_PRESS_THRESHOLD = 2'd0,
        REG_INTENSITY_MAX   = 2'd1,
        REG_ID_MAX          = 2'd2
    } reg_index_t;

    localparam logic [THR_WIDTH-1:0] PRESS_THRESHOLD_RST = 16'd5000;
    localparam logic [VAL_WIDTH-1:0] INTENSITY_MAX_RST   = 4'd10;
    localparam logic [VAL_WIDTH-1:0] ID_MAX_RST          = 4'd15;

    typedef struct packed {
        logic     fire;
        ev_kind_t kind;
    } menu_event_t;

    typedef struct packed {
        logic                 ui_exit;
        logic                 transmit;
        logic [VAL_WIDTH-1:0] beacon_id;
        logic [VAL_WIDTH-1:0] intensity;
        entry_t               selected;
        logic                 in_list;
    } menu_view_t;

endpackage

// ===== src/rsm_menu.sv =====
// ----------------------------------------------------------------------------
// Rotary settings menu state
// Holds the four-entry menu and applies one event per cycle.
// ----------------------------------------------------------------------------
module rsm_menu
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rsm_pkg::menu_event_t           ev,
    input  logic [rsm_pkg::VAL_WIDTH-1:0]  intensity_max,
    input  logic [rsm_pkg::VAL_WIDTH-1:0]  id_max,
    output rsm_pkg::menu_view_t            view
);

    logic                          browsing_reg,     browsing_next;
    rsm_pkg::entry_t               entry_reg,        entry_next;
    logic [rsm_pkg::VAL_WIDTH-1:0] intensity_reg,    intensity_next;
    logic [rsm_pkg::VAL_WIDTH-1:0] beacon_id_reg,    beacon_id_next;
    logic                          transmitting_reg, transmitting_next;
    logic                          leave;

    function automatic logic [rsm_pkg::VAL_WIDTH-1:0] step_value(
        input logic [rsm_pkg::VAL_WIDTH-1:0] v,
        input logic [rsm_pkg::VAL_WIDTH-1:0] top,
        input logic                          up
    );
        logic [rsm_pkg::VAL_WIDTH-1:0] r;
        if (up)
            r = (v < top) ? v + 1'b1 : '0;
        else
            r = (v != '0) ? v - 1'b1 : top;
        return r;
    endfunction

    always_comb
    begin
        browsing_next     = browsing_reg;
        entry_next        = entry_reg;
        intensity_next    = intensity_reg;
        beacon_id_next    = beacon_id_reg;
        transmitting_next = transmitting_reg;
        leave             = 1'b0;
        if (ev.fire)
        begin
            if (browsing_reg)
            begin
                case (ev.kind)
                    rsm_pkg::EV_CW:
                        entry_next = rsm_pkg::entry_t'(entry_reg + 2'd1);
                    rsm_pkg::EV_CCW:
                        entry_next = rsm_pkg::entry_t'(entry_reg - 2'd1);
                    default:
                    begin
                        case (entry_reg)
                            rsm_pkg::ENTRY_EXIT:     leave = 1'b1;
                            rsm_pkg::ENTRY_TRANSMIT: transmitting_next = ~transmitting_reg;
                            default:                 browsing_next = 1'b0;
                        endcase
                    end
                endcase
            end
            else if (ev.kind == rsm_pkg::EV_PRESS)
            begin
                browsing_next = 1'b1;
            end
            else
            begin
                case (entry_reg)
                    rsm_pkg::ENTRY_INTENSITY:
                        intensity_next = step_value(intensity_reg, intensity_max,
                                                    ev.kind == rsm_pkg::EV_CW);
                    rsm_pkg::ENTRY_ID:
                        beacon_id_next = step_value(beacon_id_reg, id_max,
                                                    ev.kind == rsm_pkg::EV_CW);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            browsing_reg     <= 1'b1;
            entry_reg        <= rsm_pkg::ENTRY_EXIT;
            intensity_reg    <= '0;
            beacon_id_reg    <= '0;
            transmitting_reg <= 1'b0;
        end
        else
        begin
            browsing_reg     <= browsing_next;
            entry_reg        <= entry_next;
            intensity_reg    <= intensity_next;
            beacon_id_reg    <= beacon_id_next;
            transmitting_reg <= transmitting_next;
        end
    end

    always_comb
    begin
        view.ui_exit   = leave;
        view.transmit  = transmitting_next;
        view.beacon_id = beacon_id_next;
        view.intensity = intensity_next;
        view.selected  = entry_next;
        view.in_list   = browsing_next;
    end

endmodule

// ===== src/rotary_encoder_settings_menu_unit.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder settings menu
// Turns encoder and button samples into menu events and settings updates.
// Registers: a sample transfer loads the input register; its result is then
// held in the result register until it transfers.
// Throughput: one sample per cycle while the output is not stalled; samples without an event give no result.
// Reset: asynchronous, clears the integrator, menu and registers to defaults.
// ----------------------------------------------------------------------------
module rotary_encoder_settings_menu_unit
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // pin_a, pin_b, button
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // in_list, selected[2], intensity_out[4], id_out[4], transmit_out, ui_exit
    output logic [15:0]                    m_axis_tdata,
    output logic [1:0]                     m_axis_tuser,  // event_kind
    input  logic                           cfg_wr_en,
    input  logic [rsm_pkg::IDX_WIDTH-1:0]  cfg_index,
    input  logic [rsm_pkg::THR_WIDTH-1:0]  cfg_wdata
);

    localparam int unsigned CMP_WIDTH =
        (COUNT_WIDTH > rsm_pkg::THR_WIDTH) ? COUNT_WIDTH : rsm_pkg::THR_WIDTH;

    logic [rsm_pkg::THR_WIDTH-1:0] threshold_reg;
    logic [rsm_pkg::VAL_WIDTH-1:0] intensity_max_reg;
    logic [rsm_pkg::VAL_WIDTH-1:0] id_max_reg;

    logic                   s1_valid_reg;
    logic [2:0]             s1_pins_reg;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   out_valid_reg;
    logic [15:0]            out_data_reg;
    rsm_pkg::ev_kind_t      out_kind_reg;

    logic                   advance;
    logic                   pin_a, pin_b, btn;
    logic [COUNT_WIDTH-1:0] count_up;
    logic                   press;
    rsm_pkg::menu_event_t   ev;
    rsm_pkg::menu_view_t    view;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= rsm_pkg::PRESS_THRESHOLD_RST;
            intensity_max_reg <= rsm_pkg::INTENSITY_MAX_RST;
            id_max_reg        <= rsm_pkg::ID_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rsm_pkg::REG_PRESS_THRESHOLD: threshold_reg <= cfg_wdata;
                rsm_pkg::REG_INTENSITY_MAX:
                    intensity_max_reg <= cfg_wdata[rsm_pkg::VAL_WIDTH-1:0];
                rsm_pkg::REG_ID_MAX:
                    id_max_reg <= cfg_wdata[rsm_pkg::VAL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            s1_pins_reg <= s_axis_tdata[2:0];
    end

    assign pin_a = s1_pins_reg[0];
    assign pin_b = s1_pins_reg[1];
    assign btn   = s1_pins_reg[2];

    always_comb
    begin
        count_up = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        press    = btn && (CMP_WIDTH'(count_up) >= CMP_WIDTH'(threshold_reg));
        ev.fire  = advance && (press || (pin_a != pin_b));
        if (press)
            ev.kind = rsm_pkg::EV_PRESS;
        else if (pin_a)
            ev.kind = rsm_pkg::EV_CCW;
        else
            ev.kind = rsm_pkg::EV_CW;

        count_next = count_reg;
        if (advance)
        begin
            if (ev.fire)
                count_next = '0;
            else if (btn)
                count_next = count_up;
            else if (count_reg != '0)
                count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    rsm_menu u_menu
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev            (ev),
        .intensity_max (intensity_max_reg),
        .id_max        (id_max_reg),
        .view          (view)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ev.fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ev.fire)
        begin
            out_kind_reg <= ev.kind;
            out_data_reg <= {3'b000, view};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

// ===== tb/rotary_encoder_settings_menu_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder settings menu testbench
// Streams encoder and button samples into the unit with random bursts and
// output stalls, predicts every menu event from a local copy of the
// integrator, menu state and registers, and checks each result transfer
// field by field. Directed tests cover the menu walk, presses, wraparound,
// integrator limits and register extremes; random phases follow.
// ----------------------------------------------------------------------------
module rotary_encoder_settings_menu_unit_tb;

    localparam logic [rsm_pkg::IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        rsm_pkg::ev_kind_t   kind;
        rsm_pkg::menu_view_t view;
    } menu_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    logic                          cfg_wr_en = 1'b0;
    logic [rsm_pkg::IDX_WIDTH-1:0] cfg_index = '0;
    logic [rsm_pkg::THR_WIDTH-1:0] cfg_wdata = '0;

    // predicted block state
    logic [rsm_pkg::THR_WIDTH-1:0] thr_reg = rsm_pkg::PRESS_THRESHOLD_RST;
    logic [rsm_pkg::VAL_WIDTH-1:0] intensity_top = rsm_pkg::INTENSITY_MAX_RST;
    logic [rsm_pkg::VAL_WIDTH-1:0] id_top = rsm_pkg::ID_MAX_RST;
    logic [15:0]                   hold_count = '0;
    logic                          browsing_list = 1'b1;
    logic [1:0]                    sel_entry = '0;
    logic [rsm_pkg::VAL_WIDTH-1:0] intensity_val = '0;
    logic [rsm_pkg::VAL_WIDTH-1:0] beacon_val = '0;
    logic                          tx_on = 1'b0;

    menu_result_t pending_views[$];

    int unsigned error_count = 0;
    int unsigned sample_total = 0;
    int unsigned result_total = 0;
    int unsigned press_total = 0;
    int unsigned exit_total = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    rotary_encoder_settings_menu_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pin_a, pin_b, button
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // in_list, selected, intensity, id, transmit, exit
        .m_axis_tuser  (m_axis_tuser),   // event_kind
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [rsm_pkg::VAL_WIDTH-1:0] wrap_up(
        logic [rsm_pkg::VAL_WIDTH-1:0] v,
        logic [rsm_pkg::VAL_WIDTH-1:0] top);
        return (v < top) ? v + 1'b1 : '0;
    endfunction

    function automatic logic [rsm_pkg::VAL_WIDTH-1:0] wrap_down(
        logic [rsm_pkg::VAL_WIDTH-1:0] v,
        logic [rsm_pkg::VAL_WIDTH-1:0] top);
        return (v > 0) ? v - 1'b1 : top;
    endfunction

    function void step_menu(input logic a, input logic b, input logic btn);
        logic              fire;
        rsm_pkg::ev_kind_t kind;
        logic              leave;
        menu_result_t      res;
        fire  = 1'b0;
        kind  = rsm_pkg::EV_CW;
        leave = 1'b0;
        if (a != b)
        begin
            kind = a ? rsm_pkg::EV_CCW : rsm_pkg::EV_CW;
            fire = 1'b1;
        end
        if (btn)
        begin
            if (hold_count != '1)
                hold_count = hold_count + 1'b1;
            if (hold_count >= thr_reg)
            begin
                kind = rsm_pkg::EV_PRESS;
                fire = 1'b1;
            end
        end
        else if (hold_count > 0)
            hold_count = hold_count - 1'b1;
        if (!fire)
            return;
        hold_count = '0;
        if (browsing_list)
        begin
            if (kind == rsm_pkg::EV_CW)
                sel_entry = sel_entry + 1'b1;
            else if (kind == rsm_pkg::EV_CCW)
                sel_entry = sel_entry - 1'b1;
            else if (sel_entry == rsm_pkg::ENTRY_EXIT)
                leave = 1'b1;
            else if (sel_entry == rsm_pkg::ENTRY_TRANSMIT)
                tx_on = ~tx_on;
            else
                browsing_list = 1'b0;
        end
        else if (kind == rsm_pkg::EV_PRESS)
            browsing_list = 1'b1;
        else if (sel_entry == rsm_pkg::ENTRY_INTENSITY)
            intensity_val = (kind == rsm_pkg::EV_CW)
                          ? wrap_up(intensity_val, intensity_top)
                          : wrap_down(intensity_val, intensity_top);
        else if (sel_entry == rsm_pkg::ENTRY_ID)
            beacon_val = (kind == rsm_pkg::EV_CW) ? wrap_up(beacon_val, id_top)
                                                  : wrap_down(beacon_val, id_top);
        res.kind           = kind;
        res.view.ui_exit   = leave;
        res.view.transmit  = tx_on;
        res.view.beacon_id = beacon_val;
        res.view.intensity = intensity_val;
        res.view.selected  = rsm_pkg::entry_t'(sel_entry);
        res.view.in_list   = browsing_list;
        pending_views.push_back(res);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            sample_total <= sample_total + 1;
            step_menu(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2]);
        end
    end

    always @(posedge clk)
    begin : check_results
        menu_result_t got;
        menu_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = rsm_pkg::ev_kind_t'(m_axis_tuser);
            got.view = rsm_pkg::menu_view_t'(m_axis_tdata[12:0]);
            result_total = result_total + 1;
            if (got.kind == rsm_pkg::EV_PRESS)
                press_total = press_total + 1;
            if (got.view.ui_exit)
                exit_total = exit_total + 1;
            if (pending_views.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count <= 10)
                    $display("unexpected result: kind=%0d tdata=%h", got.kind, m_axis_tdata);
            end
            else
            begin
                want = pending_views.pop_front();
                if (got.kind != want.kind || got.view.in_list != want.view.in_list ||
                    got.view.selected != want.view.selected ||
                    got.view.intensity != want.view.intensity ||
                    got.view.beacon_id != want.view.beacon_id ||
                    got.view.transmit != want.view.transmit ||
                    got.view.ui_exit != want.view.ui_exit)
                begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display({"mismatch: expected kind=%0d list=%0b sel=%0d int=%0d ",
                                  "id=%0d tx=%0b exit=%0b, got kind=%0d list=%0b sel=%0d ",
                                  "int=%0d id=%0d tx=%0b exit=%0b"},
                                 want.kind, want.view.in_list, want.view.selected,
                                 want.view.intensity, want.view.beacon_id,
                                 want.view.transmit, want.view.ui_exit,
                                 got.kind, got.view.in_list, got.view.selected,
                                 got.view.intensity, got.view.beacon_id,
                                 got.view.transmit, got.view.ui_exit);
                end
            end
        end
    end

    // output stalls: always ready, coin toss, or mostly stalled
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 40);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task send_sample(input logic a, input logic b, input logic btn);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 4) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, btn, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task write_reg(input logic [rsm_pkg::IDX_WIDTH-1:0] idx,
                   input logic [rsm_pkg::THR_WIDTH-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rsm_pkg::REG_PRESS_THRESHOLD: thr_reg = value;
            rsm_pkg::REG_INTENSITY_MAX:   intensity_top = value[rsm_pkg::VAL_WIDTH-1:0];
            rsm_pkg::REG_ID_MAX:          id_top = value[rsm_pkg::VAL_WIDTH-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task test_menu_walk;
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        drain();
    endtask

    task test_presses;
        write_reg(rsm_pkg::REG_PRESS_THRESHOLD, 16'd1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        drain();
    endtask

    task test_value_limits;
        write_reg(rsm_pkg::REG_PRESS_THRESHOLD, 16'd2);
        write_reg(rsm_pkg::REG_INTENSITY_MAX, 16'hfff_f);
        write_reg(rsm_pkg::REG_ID_MAX, 16'h0000);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        drain();
        // lower the intensity maximum to 5, from the low bits of the written word
        write_reg(rsm_pkg::REG_INTENSITY_MAX, 16'h5a35);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        drain();
    endtask

    task test_zero_threshold;
        write_reg(rsm_pkg::REG_PRESS_THRESHOLD, 16'd0);
        write_reg(REG_UNUSED, 16'hffff);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task test_count_top;
        write_reg(rsm_pkg::REG_PRESS_THRESHOLD, 16'hffff);
        repeat (100) send_sample(1'b0, 1'b0, 1'b1);
        repeat (3) send_sample(1'b1, 1'b1, 1'b1);
        repeat (5) send_sample(1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task test_random_phase(input logic [rsm_pkg::THR_WIDTH-1:0] thr,
                           input logic [3:0] imax,
                           input logic [3:0] idmax, input int unsigned count);
        int unsigned hold;
        logic        a;
        logic        b;
        logic        btn;
        hold = 0;
        write_reg(rsm_pkg::REG_PRESS_THRESHOLD, thr);
        write_reg(rsm_pkg::REG_INTENSITY_MAX, {12'($urandom), imax});
        write_reg(rsm_pkg::REG_ID_MAX, {12'($urandom), idmax});
        repeat (count)
        begin
            if (hold == 0 && $urandom_range(0, 3) == 0)
                hold = $urandom_range(1, 10);
            a = $urandom_range(0, 1);
            if (hold > 0)
            begin
                hold = hold - 1;
                b = ($urandom_range(0, 9) == 0) ? ~a : a;
                btn = ($urandom_range(0, 7) != 0);
            end
            else
            begin
                b = $urandom_range(0, 1);
                btn = ($urandom_range(0, 5) == 0);
            end
            send_sample(a, b, btn);
        end
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_menu_walk();
        test_presses();
        test_value_limits();
        test_zero_threshold();
        test_count_top();
        test_random_phase(16'd1, 4'd15, 4'd0, 280);
        test_random_phase(16'd0, 4'd0, 4'd15, 280);
        test_random_phase(16'd3, 4'd10, 4'd15, 280);
        test_random_phase(16'($urandom_range(2, 8)), 4'($urandom), 4'($urandom), 280);
        test_random_phase(16'd6, 4'($urandom), 4'($urandom), 280);
        test_random_phase(16'($urandom_range(30000, 65535)), 4'd7, 4'd9, 280);
        $display("Run covered %0d samples and %0d menu events (%0d presses, %0d exits).",
                 sample_total, result_total, press_total, exit_total);
        $display("Thresholds 0, 1 and the counter top were used, value limits 0 to 15.");
        if (error_count == 0 && pending_views.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
